// ----- src/rdc_pkg.sv -----
package rdc_pkg;

  // Default significant width of the input value.
  localparam int VALUE_BITS_DEF = 31;

  // ASCII offsets for hexadecimal characters.
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_ALPHA = 8'd55;
  localparam logic [3:0] HEX_TEN     = 4'd10;

  // Conversion modes carried in the request.
  typedef enum logic [1:0] {
    MODE_BIN = 2'd0,
    MODE_OCT = 2'd1,
    MODE_HEX = 2'd2,
    MODE_BCD = 2'd3
  } mode_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_LOAD     = 3'd1,
    OP_DAB      = 3'd2,
    OP_BCD_LOAD = 3'd3,
    OP_SKIP     = 3'd4,
    OP_EMIT     = 3'd5
  } op_t;

  // Branch conditions tested by the sequencer.
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_INPUT     = 3'd1,
    C_NOT_BCD   = 3'd2,
    C_LAST_BIT  = 3'd3,
    C_SKIP_END  = 3'd4,
    C_CNT_ZERO  = 3'd5,
    C_EMIT_LAST = 3'd6
  } cond_t;

  localparam int PC_BITS = 3;
  typedef logic [PC_BITS-1:0] pc_t;

  // Program addresses.
  localparam pc_t STEP_WAIT   = 3'd0;
  localparam pc_t STEP_ROUTE  = 3'd1;
  localparam pc_t STEP_DABBLE = 3'd2;
  localparam pc_t STEP_UNPACK = 3'd3;
  localparam pc_t STEP_SKIP   = 3'd4;
  localparam pc_t STEP_CHECK  = 3'd5;
  localparam pc_t STEP_EMIT   = 3'd6;

  // One control word: operation, branch condition and target, and whether
  // a false condition holds the step or falls through to the next one.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  hold;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic have_input;
    logic is_bcd;
    logic last_bit;
    logic skip_end;
    logic cnt_zero;
    logic emit_last;
  } status_t;

  // Control store.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      STEP_WAIT:   w = '{op: OP_LOAD,     cond: C_INPUT,     target: STEP_ROUTE,  hold: 1'b1};
      STEP_ROUTE:  w = '{op: OP_NOP,      cond: C_NOT_BCD,   target: STEP_SKIP,   hold: 1'b0};
      STEP_DABBLE: w = '{op: OP_DAB,      cond: C_LAST_BIT,  target: STEP_UNPACK, hold: 1'b1};
      STEP_UNPACK: w = '{op: OP_BCD_LOAD, cond: C_ALWAYS,    target: STEP_SKIP,   hold: 1'b0};
      STEP_SKIP:   w = '{op: OP_SKIP,     cond: C_SKIP_END,  target: STEP_CHECK,  hold: 1'b1};
      STEP_CHECK:  w = '{op: OP_NOP,      cond: C_CNT_ZERO,  target: STEP_WAIT,   hold: 1'b0};
      STEP_EMIT:   w = '{op: OP_EMIT,     cond: C_EMIT_LAST, target: STEP_WAIT,   hold: 1'b1};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: STEP_WAIT,   hold: 1'b0};
    endcase
    return w;
  endfunction

  // Decimal digits needed for the largest value of the given bit width.
  function automatic int dec_digits(int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

// ----- src/radix_digit_converter.sv -----
// The step sequencer runs one item at a time: it loads the value, runs the double
// dabble loop for BCD items, skips the leading zero digits and then sends the rest as
// beats. The double dabble loop takes one value bit per cycle. A zero value sends no beat.
// Reset (rst, synchronous) returns the sequencer to its wait step and empties the output.
module radix_digit_converter #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,  // value
  input  logic [1:0]                         s_tuser,  // req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,  // symbol
  output logic                               m_tlast   // last
);
  import rdc_pkg::*;

  op_t     op;
  status_t status;

  // Program sequencer.
  rdc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  // Conversion datapath and output register.
  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .in_valid   (s_tvalid),
    .in_mode    (s_tuser),
    .in_value   (s_tdata[VALUE_BITS-1:0]),
    .in_ready   (s_tready),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_symbol (m_tdata),
    .out_last   (m_tlast),
    .status     (status)
  );

endmodule

// ----- src/rdc_sequencer.sv -----
module rdc_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  rdc_pkg::status_t status,
  output rdc_pkg::op_t     op
);
  import rdc_pkg::*;

  pc_t    pc;
  pc_t    pc_next;
  uword_t word;
  logic   taken;

  // Fetch the control word for the current step.
  assign word = ucode(pc);
  assign op   = word.op;

  // Evaluate the branch condition.
  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    taken = 1'b1;
      C_INPUT:     taken = status.have_input;
      C_NOT_BCD:   taken = !status.is_bcd;
      C_LAST_BIT:  taken = status.last_bit;
      C_SKIP_END:  taken = status.skip_end;
      C_CNT_ZERO:  taken = status.cnt_zero;
      C_EMIT_LAST: taken = status.emit_last;
      default:     taken = 1'b1;
    endcase
  end

  // Branch, hold, or fall through.
  always_comb begin
    if (taken) begin
      pc_next = word.target;
    end else if (word.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- src/rdc_datapath.sv -----
module rdc_datapath #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rdc_pkg::op_t          op,
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_symbol,
  output logic                  out_last,
  output rdc_pkg::status_t      status
);
  import rdc_pkg::*;

  localparam int DIGITS    = dec_digits(VALUE_BITS);
  localparam int BCD_BITS  = 4 * DIGITS;
  localparam int OCT_LEN   = ((VALUE_BITS + 2) / 3) * 3;
  localparam int HEX_LEN   = ((VALUE_BITS + 3) / 4) * 4;
  localparam int RAD_MAX   = (OCT_LEN > HEX_LEN) ? OCT_LEN : HEX_LEN;
  localparam int WORK_BITS = (BCD_BITS > RAD_MAX) ? BCD_BITS : RAD_MAX;
  localparam int CNT_BITS  = $clog2(WORK_BITS + 1);
  localparam int BCNT_BITS = $clog2(VALUE_BITS + 1);

  mode_t                  mode;
  logic [VALUE_BITS-1:0]  src;
  logic [BCD_BITS-1:0]    bcd;
  logic [BCD_BITS-1:0]    bcd_adj;
  logic [BCNT_BITS-1:0]   bitcnt;
  logic [WORK_BITS-1:0]   work;
  logic [CNT_BITS-1:0]    cnt;
  logic [CNT_BITS-1:0]    skip_w;
  logic [CNT_BITS-1:0]    emit_w;
  logic                   top_zero;
  logic [3:0]             nib;
  logic [7:0]             digit;
  logic                   out_free;
  logic                   emit_fire;

  assign in_ready  = (op == OP_LOAD) && !rst;
  assign out_free  = !out_valid || out_ready;
  assign emit_fire = (op == OP_EMIT) && out_free;
  assign nib       = work[WORK_BITS-1 -: 4];

  // Digit widths and the leading digit for the current mode.
  always_comb begin
    unique case (mode)
      MODE_BIN: begin
        skip_w   = CNT_BITS'(1);
        emit_w   = CNT_BITS'(1);
        top_zero = !work[WORK_BITS-1];
        digit    = 8'(work[WORK_BITS-1]);
      end
      MODE_OCT: begin
        skip_w   = CNT_BITS'(3);
        emit_w   = CNT_BITS'(3);
        top_zero = (work[WORK_BITS-1 -: 3] == 3'd0);
        digit    = 8'(work[WORK_BITS-1 -: 3]);
      end
      MODE_HEX: begin
        skip_w   = CNT_BITS'(4);
        emit_w   = CNT_BITS'(4);
        top_zero = (nib == 4'd0);
        digit    = (nib < HEX_TEN) ? (ASCII_ZERO + 8'(nib)) : (ASCII_ALPHA + 8'(nib));
      end
      default: begin
        skip_w   = CNT_BITS'(4);
        emit_w   = CNT_BITS'(1);
        top_zero = (nib == 4'd0);
        digit    = 8'(work[WORK_BITS-1]);
      end
    endcase
  end

  // Add-3 correction on every decimal nibble before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Status for the sequencer.
  always_comb begin
    status.have_input = in_valid;
    status.is_bcd     = (mode == MODE_BCD);
    status.last_bit   = (bitcnt == BCNT_BITS'(1));
    status.cnt_zero   = (cnt == '0);
    status.skip_end   = (cnt == '0) || !top_zero;
    status.emit_last  = out_free && (cnt == emit_w);
  end

  // Working registers: load, double dabble, leading-zero skip and emission.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        if (in_valid) begin
          mode   <= mode_t'(in_mode);
          src    <= in_value;
          bcd    <= '0;
          bitcnt <= BCNT_BITS'(VALUE_BITS);
          unique case (mode_t'(in_mode))
            MODE_BIN: begin
              work <= WORK_BITS'(in_value) << (WORK_BITS - VALUE_BITS);
              cnt  <= CNT_BITS'(VALUE_BITS);
            end
            MODE_OCT: begin
              work <= WORK_BITS'(in_value) << (WORK_BITS - OCT_LEN);
              cnt  <= CNT_BITS'(OCT_LEN);
            end
            default: begin
              work <= WORK_BITS'(in_value) << (WORK_BITS - HEX_LEN);
              cnt  <= CNT_BITS'(HEX_LEN);
            end
          endcase
        end
      end
      OP_DAB: begin
        bcd    <= {bcd_adj[BCD_BITS-2:0], src[VALUE_BITS-1]};
        src    <= src << 1;
        bitcnt <= bitcnt - 1'b1;
      end
      OP_BCD_LOAD: begin
        work <= WORK_BITS'(bcd) << (WORK_BITS - BCD_BITS);
        cnt  <= CNT_BITS'(BCD_BITS);
      end
      OP_SKIP: begin
        if (top_zero && cnt != '0) begin
          work <= work << skip_w;
          cnt  <= cnt - skip_w;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          work <= work << emit_w;
          cnt  <= cnt - emit_w;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_symbol <= digit;
      out_last   <= (cnt == emit_w);
    end
  end

  // An emission step always has digits left to send.
  assert property (@(posedge clk) disable iff (rst) (op == OP_EMIT) |-> (cnt != '0))
    else $error("emission step entered with no digits left");

  // The double dabble loop never runs past the value's width.
  assert property (@(posedge clk) disable iff (rst) (op == OP_DAB) |-> (bitcnt != '0))
    else $error("double dabble step with bit count at zero");

  // Sending the final digit leaves a valid beat marked last.
  assert property (@(posedge clk) disable iff (rst)
      (emit_fire && cnt == emit_w) |=> (out_valid && out_last))
    else $error("final digit not marked last");

  // The skip step stops at the first nonzero digit.
  assert property (@(posedge clk) disable iff (rst)
      (op == OP_SKIP && !top_zero && cnt != '0) |=> $stable(cnt))
    else $error("skip step consumed a nonzero leading digit");

endmodule
